### rtl/core/assert_macros.svh
// Assertion macros shared by the field bit reverse RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define SFBR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define SFBR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/sfbr_pkg.sv
// Package of types, constants and helper functions for the field bit reverse core.
package sfbr_pkg;

	// Word geometry
	localparam int WORD_BITS = 64;
	localparam int IDX_W     = $clog2(WORD_BITS);
	localparam int COV_W     = $clog2(WORD_BITS + 1);
	localparam int NUM_BYTES = WORD_BITS / 8;

	// Port widths fixed by the register and field definitions
	localparam int PORT_W      = 64;
	localparam int COV_REG_W   = 7;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;

	// Register reset values
	localparam logic [PORT_W-1:0]    START_MASK_RESET = PORT_W'(1);
	localparam logic [COV_REG_W-1:0] COVERED_RESET    = COV_REG_W'(64);

	// Register indexes on the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BYTE_FLIP  = 2'd0,
		CFG_START_MASK = 2'd1,
		CFG_COVERED    = 2'd2
	} cfg_reg_t;

	// Register contents as seen by the datapath
	typedef struct packed {
		logic                 byte_flip_first;
		logic [PORT_W-1:0]    field_start_mask;
		logic [COV_REG_W-1:0] covered_bits;
	} sfbr_cfg_t;

	typedef logic [WORD_BITS-1:0]            word_t;
	typedef logic [WORD_BITS-1:0][IDX_W-1:0] src_map_t;

	// Reverse bit order inside each full byte; a partial top byte passes through.
	function automatic word_t flip_bytes(input word_t w);
		word_t r;
		r = w;
		for (int b = 0; b < NUM_BYTES; b++) begin
			for (int j = 0; j < 8; j++) begin
				r[b*8 + 7 - j] = w[b*8 + j];
			end
		end
		return r;
	endfunction

endpackage

### rtl/core/sfbr_in_if.sv
// Request channel carrying one data word per transfer.
interface sfbr_in_if;
	logic                          valid;
	logic                          ready;
	logic [sfbr_pkg::PORT_W-1:0]   data_word;

	modport source (output valid, output data_word, input ready);
	modport sink   (input valid, input data_word, output ready);
endinterface

### rtl/core/sfbr_out_if.sv
// Result channel carrying one result word per transfer.
interface sfbr_out_if;
	logic                          valid;
	logic                          ready;
	logic [sfbr_pkg::PORT_W-1:0]   result_word;

	modport source (output valid, output result_word, input ready);
	modport sink   (input valid, input result_word, output ready);
endinterface

### rtl/core/segmented_field_bit_reverse_core.sv
// Top level of the field bit reverse core: request pipeline, result register, checks.
// Each request carries one data word and yields one result word. The core takes a new
// request every cycle unless stalled and holds a three-deep pipeline: the input register
// (optional bit flip inside each byte applied on the way in), a stage that registers the
// decoded field boundaries with the data, and the result register that feeds the result
// channel. Stalls on the result side fill empty stages first and only then lower ready.
// Registers are written through a plain write port; a write applies to requests accepted
// after it (byte flip) or leaving the input register later (mask, covered width). Fields
// start at bit 0 and at each set bit of the start mask below the covered width, bits of
// each field are mirrored in place, and bits at or above the covered width read as zero.
`include "assert_macros.svh"

module segmented_field_bit_reverse_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sfbr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sfbr_pkg::CFG_DATA_W-1:0]    cfg_data,
	sfbr_in_if.sink                            data_ch,
	sfbr_out_if.source                         result_ch
);

	sfbr_pkg::sfbr_cfg_t  cfg;
	sfbr_pkg::word_t      word_in;
	sfbr_pkg::src_map_t   src_map;
	logic [sfbr_pkg::WORD_BITS-1:0] live_map;
	sfbr_pkg::word_t      permuted;

	logic                 valid_s1;
	sfbr_pkg::word_t      data_s1;
	logic                 valid_s2;
	sfbr_pkg::word_t      data_s2;
	sfbr_pkg::src_map_t   src_s2;
	logic [sfbr_pkg::WORD_BITS-1:0] live_s2;
	logic                 result_valid_q;
	sfbr_pkg::word_t      result_q;

	logic                 adv_s1;
	logic                 adv_s2;
	logic                 adv_s3;

	sfbr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfbr_src_map u_map (
		.cfg  (cfg),
		.src  (src_map),
		.live (live_map)
	);

	sfbr_permute u_perm (
		.data   (data_s2),
		.src    (src_s2),
		.live   (live_s2),
		.result (permuted)
	);

	// Stage advance: a stage moves when it is empty or its successor moves
	assign adv_s3 = !result_valid_q || result_ch.ready;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign data_ch.ready = adv_s1;

	// Apply the optional byte flip on the way in
	always_comb begin
		if (cfg.byte_flip_first) begin
			word_in = sfbr_pkg::flip_bytes(data_ch.data_word[sfbr_pkg::WORD_BITS-1:0]);
		end else begin
			word_in = data_ch.data_word[sfbr_pkg::WORD_BITS-1:0];
		end
	end

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= data_ch.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				result_valid_q <= valid_s2;
			end
		end
	end

	// Advance payload; hold while the next stage is blocked
	always_ff @(posedge clk) begin
		if (adv_s1 && data_ch.valid) begin
			data_s1 <= word_in;
		end
		if (adv_s2 && valid_s1) begin
			data_s2 <= data_s1;
			src_s2  <= src_map;
			live_s2 <= live_map;
		end
		if (adv_s3 && valid_s2) begin
			result_q <= permuted;
		end
	end

	assign result_ch.valid       = result_valid_q;
	assign result_ch.result_word = sfbr_pkg::PORT_W'(result_q);

	// Checks on pipeline bookkeeping
	`SFBR_ASSERT_NEXT(a_accept_fills_s1, data_ch.valid && data_ch.ready, valid_s1, "accepted request did not reach the input stage")
	`SFBR_ASSERT_NOW(a_stall_only_when_full, !data_ch.ready, valid_s1 && valid_s2 && result_valid_q, "ready dropped with an empty stage")
	`SFBR_ASSERT_NEXT(a_s2_holds_when_blocked, valid_s2 && !adv_s3, valid_s2 && $stable(data_s2) && $stable(src_s2), "blocked stage two lost its contents")

endmodule

### rtl/core/sfbr_cfg_regs.sv
// Configuration register file of the field bit reverse core.
module sfbr_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sfbr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sfbr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output sfbr_pkg::sfbr_cfg_t                cfg
);

	sfbr_pkg::sfbr_cfg_t cfg_q;

	// Write the addressed register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.byte_flip_first  <= 1'b0;
			cfg_q.field_start_mask <= sfbr_pkg::START_MASK_RESET;
			cfg_q.covered_bits     <= sfbr_pkg::COVERED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sfbr_pkg::CFG_BYTE_FLIP: begin
					cfg_q.byte_flip_first <= cfg_data[0];
				end
				sfbr_pkg::CFG_START_MASK: begin
					cfg_q.field_start_mask <= cfg_data[sfbr_pkg::PORT_W-1:0];
				end
				sfbr_pkg::CFG_COVERED: begin
					cfg_q.covered_bits <= cfg_data[sfbr_pkg::COV_REG_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/sfbr_src_map.sv
// Field boundary decode: source bit index and live flag for every result bit.
module sfbr_src_map (
	input  sfbr_pkg::sfbr_cfg_t                   cfg,
	output sfbr_pkg::src_map_t                    src,
	output logic [sfbr_pkg::WORD_BITS-1:0]        live
);

	localparam int W = sfbr_pkg::WORD_BITS;

	logic [sfbr_pkg::COV_W-1:0] cov;
	logic [W-1:0]               starts;

	// Saturate the covered width to the word
	always_comb begin
		if (cfg.covered_bits > sfbr_pkg::COV_REG_W'(W)) begin
			cov = sfbr_pkg::COV_W'(W);
		end else begin
			cov = cfg.covered_bits[sfbr_pkg::COV_W-1:0];
		end
	end

	// Effective field starts: bit 0 always, others only inside the covered span
	always_comb begin
		for (int p = 0; p < W; p++) begin
			if (p == 0) begin
				starts[p] = 1'b1;
			end else begin
				starts[p] = cfg.field_start_mask[p] && (sfbr_pkg::COV_W'(p) < cov);
			end
		end
	end

	// Per result bit: nearest start at or below, next start above (or cov), mirror
	for (genvar d = 0; d < W; d++) begin : g_bit
		logic [sfbr_pkg::COV_W-1:0] lo;
		logic [sfbr_pkg::COV_W-1:0] hi;
		logic [sfbr_pkg::COV_W-1:0] mirror;

		always_comb begin
			lo = '0;
			for (int p = 0; p < W; p++) begin
				if (p <= d && starts[p]) begin
					lo = sfbr_pkg::COV_W'(p);
				end
			end
			hi = cov;
			for (int p = W - 1; p >= 0; p--) begin
				if (p > d && starts[p]) begin
					hi = sfbr_pkg::COV_W'(p);
				end
			end
			mirror = lo + hi - sfbr_pkg::COV_W'(1) - sfbr_pkg::COV_W'(d);
		end

		assign src[d]  = mirror[sfbr_pkg::IDX_W-1:0];
		assign live[d] = sfbr_pkg::COV_W'(d) < cov;
	end

endmodule

### rtl/core/sfbr_permute.sv
// Bit permutation: each result bit selects its source bit or gives zero.
module sfbr_permute (
	input  sfbr_pkg::word_t                       data,
	input  sfbr_pkg::src_map_t                    src,
	input  logic [sfbr_pkg::WORD_BITS-1:0]        live,
	output sfbr_pkg::word_t                       result
);

	// Select the mirrored bit inside the field; zero above the covered span
	always_comb begin
		for (int d = 0; d < sfbr_pkg::WORD_BITS; d++) begin
			result[d] = live[d] & data[src[d]];
		end
	end

endmodule
